// ===== rtl/ps2_mouse_packet_tracker_macros.svh =====
// assertion macros for the ps2 mouse packet tracker
// needs clk and arst_n in the scope of each use
`ifndef PS2_MOUSE_PACKET_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_MACROS_SVH

// same-cycle implication, off during reset
`define PMT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define PMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pmt_pkg.sv =====
// package for the ps2 mouse packet tracker: widths, byte phase codes,
// header bit positions and the delta and clamp helpers; no dependencies
package pmt_pkg;

	localparam int COORD_BITS = 13;
	localparam int CFG_W      = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int DELTA_W    = 10;
	localparam int SUM_W      = COORD_BITS + 2;
	localparam int LIM_W      = (CFG_W > COORD_BITS) ? CFG_W + 1 : COORD_BITS + 1;

	localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 14'd1024;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 14'd768;

	// byte phase codes
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_X      = 2'd1;
	localparam logic [1:0] PH_Y      = 2'd2;

	// header bit positions
	localparam int HDR_SYNC  = 3;
	localparam int HDR_XSIGN = 4;
	localparam int HDR_YSIGN = 5;
	localparam int HDR_XOVER = 6;
	localparam int HDR_YOVER = 7;

	// 9-bit two's complement delta widened to 10 bits, overflow adds 255 in its direction
	function automatic logic signed [DELTA_W-1:0] delta9(
		input logic [7:0] mag, input logic neg, input logic over);
		logic signed [DELTA_W-1:0] base;
		base = signed'({neg, neg, mag});
		if (!over)
			return base;
		else if (neg)
			return base - DELTA_W'(255);
		else
			return base + DELTA_W'(255);
	endfunction

	// upper limit of an axis: size minus one, zero for size zero,
	// saturated to the coordinate range
	function automatic logic [COORD_BITS-1:0] axis_limit(input logic [CFG_W-1:0] size);
		logic [LIM_W-1:0] m;
		m = LIM_W'(size) - LIM_W'(1);
		if (size == '0)
			return '0;
		else if (m > LIM_W'(COORD_MAX))
			return COORD_MAX;
		else
			return m[COORD_BITS-1:0];
	endfunction

	// saturate a signed sum into [0, hi]
	function automatic logic [COORD_BITS-1:0] clamp_axis(
		input logic signed [SUM_W-1:0] v, input logic [COORD_BITS-1:0] hi);
		if (v < 0)
			return '0;
		else if (v > signed'({2'b00, hi}))
			return hi;
		else
			return v[COORD_BITS-1:0];
	endfunction

endpackage

// ===== rtl/ps2_mouse_packet_tracker.sv =====
// ps2 mouse packet tracker top level: byte register, packet decode,
// cursor update and result register; uses pmt_pkg and the assertion macros
//
// channel   direction  handshake               payload
// in        in         in_valid / in_ready     rx_byte
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
// out       out        out_valid / out_ready   cursor_x/y, prior_x/y, buttons
//
// one byte a cycle unless a y byte is held: a byte waits in the input
// register, then for a y byte the add and clamp logic updates the position
// and loads the result register as the y byte leaves the input register
// reset clears phase and position, arms the skip flag and sets 1024x768
// while a result waits, a y byte in the input register holds; other bytes pass
// cfg writes are always taken
`include "ps2_mouse_packet_tracker_macros.svh"

module ps2_mouse_packet_tracker
	import pmt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] cursor_x,
	output logic [COORD_BITS-1:0] cursor_y,
	output logic [COORD_BITS-1:0] prior_x,
	output logic [COORD_BITS-1:0] prior_y,
	output logic                  button_left,
	output logic                  button_right,
	output logic                  button_middle
);

	logic [CFG_W-1:0]      screen_width_q, screen_height_q;
	logic                  valid_s1;
	logic [7:0]            rx_byte_s1;
	logic [1:0]            phase_q;
	logic                  skip_q;
	logic [7:0]            header_q, x_byte_q;
	logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] cursor_x_q, cursor_y_q, prior_x_q, prior_y_q;
	logic [2:0]            buttons_q;

	logic                  is_y_byte, out_free, s1_fire, emit;
	logic signed [DELTA_W-1:0] dx, dy;
	logic signed [SUM_W-1:0]   sum_x, sum_y;
	logic [COORD_BITS-1:0] new_x, new_y;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SCREEN_WIDTH)
				screen_width_q <= cfg_data;
			else if (cfg_index == REG_SCREEN_HEIGHT)
				screen_height_q <= cfg_data;
		end
	end

	// stage control: only a y byte needs room in the result register
	assign is_y_byte = !skip_q && (phase_q == PH_Y);
	assign out_free  = !out_valid_q || out_ready;
	assign s1_fire   = valid_s1 && (!is_y_byte || out_free);
	assign emit      = s1_fire && is_y_byte;
	assign in_ready  = !valid_s1 || s1_fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			rx_byte_s1 <= rx_byte;
	end

	// delta, add and clamp for the y byte
	assign dx    = delta9(x_byte_q, header_q[HDR_XSIGN], header_q[HDR_XOVER]);
	assign dy    = delta9(rx_byte_s1, header_q[HDR_YSIGN], header_q[HDR_YOVER]);
	assign sum_x = signed'({2'b00, pos_x_q}) + SUM_W'(dx);
	assign sum_y = signed'({2'b00, pos_y_q}) - SUM_W'(dy);
	assign new_x = clamp_axis(sum_x, axis_limit(screen_width_q));
	assign new_y = clamp_axis(sum_y, axis_limit(screen_height_q));

	// packet phase and position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			skip_q   <= 1'b1;
			header_q <= '0;
			x_byte_q <= '0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
		end else if (s1_fire) begin
			if (skip_q) begin
				skip_q <= 1'b0;
			end else begin
				unique case (phase_q)
					PH_X: begin
						x_byte_q <= rx_byte_s1;
						phase_q  <= PH_Y;
					end
					PH_Y: begin
						pos_x_q <= new_x;
						pos_y_q <= new_y;
						phase_q <= PH_HEADER;
					end
					default: begin
						if (rx_byte_s1[HDR_SYNC]) begin
							header_q <= rx_byte_s1;
							phase_q  <= PH_X;
						end else begin
							phase_q <= PH_HEADER;
						end
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cursor_x_q <= new_x;
			cursor_y_q <= new_y;
			prior_x_q  <= pos_x_q;
			prior_y_q  <= pos_y_q;
			buttons_q  <= header_q[2:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign cursor_x      = cursor_x_q;
	assign cursor_y      = cursor_y_q;
	assign prior_x       = prior_x_q;
	assign prior_y       = prior_y_q;
	assign button_left   = buttons_q[0];
	assign button_right  = buttons_q[1];
	assign button_middle = buttons_q[2];

	// checks
	`PMT_ASSERT_NEXT(a_y_byte_emits, valid_s1 && s1_fire && is_y_byte, out_valid_q,
		"y byte left the input register without a result")
	`PMT_ASSERT_NOW(a_result_tracks_pos, out_valid_q,
		cursor_x_q == pos_x_q && cursor_y_q == pos_y_q,
		"pending result differs from the stored position")
	`PMT_ASSERT_NEXT(a_y_byte_held, valid_s1 && is_y_byte && out_valid_q && !out_ready,
		valid_s1 && is_y_byte && $stable(pos_x_q) && $stable(pos_y_q),
		"y byte processed while the result register was full")

endmodule
